@@ design/bcl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_pkg: shared types and constants of the binary clock strip driver
// Holds the port words, the front-to-back queue word, the register set and
// the constants of the time conversion and the pixel framing.
// ----------------------------------------------------------------------------
package bcl_pkg;

  // Framing of the strips.
  localparam int NUM_STRIPS       = 3;
  localparam int PIXELS_PER_STRIP = 4;
  localparam int BITS_PER_PIXEL   = 24;

  // Field widths.
  localparam int COUNT_W = 32;
  localparam int DIGIT_W = 4;
  localparam int LEVEL_W = 3;
  localparam int UNITS_W = 8;
  localparam int COLOR_W = 24;
  localparam int TICK_W  = 9;
  localparam int STRIP_W = 2;
  localparam int PIXEL_W = 2;
  localparam int BIT_W   = 5;

  // Time conversion constants.
  localparam int DAY_HALF_MINUTES  = 1440;
  localparam int HOUR_HALF_MINUTES = 120;
  localparam int NOON_HOUR         = 12;
  localparam int DECIMAL_BASE      = 10;
  // The day length is 32 * 45; the low five bits pass through and the rest
  // is reduced modulo 45 with a reciprocal of 2^32 / 45, rounded down.
  localparam int DAY_SHIFT         = 5;
  localparam int DAY_ODD_FACTOR    = 45;
  localparam logic [26:0] RECIP_45 = 27'd95443717;

  // Register reset values.
  localparam logic [UNITS_W-1:0] LONG_UNITS_RST  = 8'd9;
  localparam logic [UNITS_W-1:0] SHORT_UNITS_RST = 8'd3;
  localparam logic [COUNT_W-1:0] TIME_OFFSET_RST = 32'd1076;
  localparam logic [COLOR_W-1:0] ON_COLOR_RST    = 24'h010000;

  // Default depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Word kinds.
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_COUNTER = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_LONG_UNITS,
    REG_SHORT_UNITS,
    REG_TIME_OFFSET,
    REG_ON_COLOR
  } reg_idx_t;

  typedef struct packed {
    logic               mode;
    logic [COUNT_W-1:0] count;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] line_levels;
    logic               busy_res;
    logic               dropped;
  } out_t;

  // Classified word handed from the front part to the back part.
  typedef struct packed {
    logic               mode;
    logic [DIGIT_W-1:0] ones;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] hour;
  } work_t;

  // Register set seen by the datapath.
  typedef struct packed {
    logic [UNITS_W-1:0] long_units;
    logic [UNITS_W-1:0] short_units;
    logic [COUNT_W-1:0] time_offset;
    logic [COLOR_W-1:0] on_color;
  } cfg_t;

endpackage

@@ design/binary_clock_led_strip_driver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_clock_led_strip_driver_unit: binary clock LED strip driver
// Each word passes the five conversion stages, the queue and the result
// register, in that order, before its result is on the ports.
// Throughput: one word per cycle while full is low; one result per word, in order.
// Reset: synchronous rst clears all control state and loads the register
// reset values; there is no clearing pass and no wait after reset.
// ----------------------------------------------------------------------------
module binary_clock_led_strip_driver_unit #(
  parameter int QUEUE_DEPTH = bcl_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bcl_pkg::in_t  item,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output bcl_pkg::out_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import bcl_pkg::*;

  cfg_t  cfg;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  work_t q_in;
  work_t q_out;

  // Configuration registers.
  bcl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front part: intake and time conversion.
  bcl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .item        (item),
    .full        (full),
    .time_offset (cfg.time_offset),
    .q_push      (q_push),
    .q_word      (q_in),
    .q_full      (q_full)
  );

  // Queue between the two parts.
  bcl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_word (q_in),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_word (q_out),
    .q_empty (q_empty)
  );

  // Back part: refresh sequencer and waveform.
  bcl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_word  (q_out),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // Only the line of the strip being sent can be high.
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> $onehot0(result.line_levels))
    else $error("more than one data line high");

  // A dropped counter word means a refresh is still running.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.dropped) |-> result.busy_res)
    else $error("dropped word reported while idle");

  // The intake only stalls when the queue has no room.
  assert property (@(posedge clk) disable iff (rst)
    full |-> q_full)
    else $error("intake stalled with room in the queue");

endmodule

@@ design/bcl_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_regs: configuration register file
// APB-style slave holding the phase lengths, the time offset and the color.
// ----------------------------------------------------------------------------
module bcl_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output bcl_pkg::cfg_t      cfg
);
  import bcl_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_units  <= LONG_UNITS_RST;
      cfg.short_units <= SHORT_UNITS_RST;
      cfg.time_offset <= TIME_OFFSET_RST;
      cfg.on_color    <= ON_COLOR_RST;
    end else if (wr_en) begin
      case (idx)
        REG_LONG_UNITS:  cfg.long_units  <= pwdata[UNITS_W-1:0];
        REG_SHORT_UNITS: cfg.short_units <= pwdata[UNITS_W-1:0];
        REG_TIME_OFFSET: cfg.time_offset <= pwdata[COUNT_W-1:0];
        REG_ON_COLOR:    cfg.on_color    <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (idx)
      REG_LONG_UNITS:  prdata = {{(32-UNITS_W){1'b0}}, cfg.long_units};
      REG_SHORT_UNITS: prdata = {{(32-UNITS_W){1'b0}}, cfg.short_units};
      REG_TIME_OFFSET: prdata = cfg.time_offset;
      REG_ON_COLOR:    prdata = {{(32-COLOR_W){1'b0}}, cfg.on_color};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ design/bcl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_front: word intake and time conversion
// Five-stage pipeline that takes words, and for counter words turns the
// half-minute count into minute ones, minute tens and hour digits.
// ----------------------------------------------------------------------------
module bcl_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  bcl_pkg::in_t                   item,
  output logic                           full,
  input  logic [bcl_pkg::COUNT_W-1:0]    time_offset,
  output logic                           q_push,
  output bcl_pkg::work_t                 q_word,
  input  logic                           q_full
);
  import bcl_pkg::*;

  localparam int XW = COUNT_W - DAY_SHIFT;
  localparam int QW = 22;
  localparam int RW = 11;

  logic advance;

  // Stage 1: offset sum.
  logic               v1, m1;
  logic [COUNT_W-1:0] sum1;
  // Stage 2: reciprocal quotient.
  logic               v2, m2;
  logic [COUNT_W-1:0] sum2;
  logic [QW-1:0]      quo2;
  // Stage 3: time of day in half-minutes.
  logic               v3, m3;
  logic [RW-1:0]      r3;
  // Stage 4: hour and minutes.
  logic               v4, m4;
  logic [DIGIT_W-1:0] hour4;
  logic [5:0]         min4;
  // Stage 5: finished digits.
  logic               v5;
  work_t              w5;

  logic [2*XW-1:0]    prod;
  logic [XW-1:0]      rem45;
  logic [11:0]        r_raw;
  logic [RW-1:0]      r_next;
  logic [DIGIT_W-1:0] hh;
  logic [RW-1:0]      hour_rem;
  logic [DIGIT_W-1:0] tens;
  logic [DIGIT_W-1:0] ones;

  // The whole pipeline holds while its last word cannot enter the queue.
  assign advance = !(v5 && q_full);
  assign full    = !advance;
  assign q_push  = v5 && !q_full;
  assign q_word  = w5;

  // Quotient of the upper sum bits by 45, low by at most one.
  assign prod = sum1[COUNT_W-1:DAY_SHIFT] * RECIP_45;

  // Remainder modulo 45 is below 90; one subtract brings it under the day.
  always_comb begin
    rem45 = sum2[COUNT_W-1:DAY_SHIFT] - XW'(quo2 * XW'(DAY_ODD_FACTOR));
    r_raw = {rem45[6:0], sum2[DAY_SHIFT-1:0]};
    if (r_raw >= 12'(DAY_HALF_MINUTES)) begin
      r_next = RW'(r_raw - 12'(DAY_HALF_MINUTES));
    end else begin
      r_next = r_raw[RW-1:0];
    end
  end

  // Hour by parallel compares against each hour boundary.
  always_comb begin
    hh = '0;
    for (int k = 1; k < NOON_HOUR; k++) begin
      if (r3 >= RW'(k * HOUR_HALF_MINUTES)) begin
        hh = hh + 4'd1;
      end
    end
    hour_rem = r3 - RW'(RW'(hh) * RW'(HOUR_HALF_MINUTES));
  end

  // Decimal split of the minutes.
  always_comb begin
    tens = '0;
    for (int k = 1; k < 6; k++) begin
      if (min4 >= 6'(k * DECIMAL_BASE)) begin
        tens = tens + 4'd1;
      end
    end
    ones = DIGIT_W'(min4 - 6'(6'(tens) * 6'(DECIMAL_BASE)));
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (advance) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (advance) begin
      m1    <= item.mode;
      sum1  <= item.count + time_offset;
      m2    <= m1;
      sum2  <= sum1;
      quo2  <= prod[COUNT_W+QW-1:COUNT_W];
      m3    <= m2;
      r3    <= r_next;
      m4    <= m3;
      hour4 <= (hh == '0) ? DIGIT_W'(NOON_HOUR) : hh;
      min4  <= hour_rem[6:1];
      w5.mode <= m4;
      w5.ones <= ones;
      w5.tens <= tens;
      w5.hour <= hour4;
    end
  end

endmodule

@@ design/bcl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_queue: queue between the front and back parts
// Small first-in first-out store of classified words with a head view.
// ----------------------------------------------------------------------------
module bcl_queue #(
  parameter int DEPTH = bcl_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  bcl_pkg::work_t wr_word,
  output logic           q_full,
  input  logic           rd,
  output bcl_pkg::work_t rd_word,
  output logic           q_empty
);
  import bcl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  work_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_wr;
  logic          do_rd;

  assign q_full  = (fill == CW'(DEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_word = slots[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_word;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ design/bcl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_back: refresh sequencer and line waveform generator
// Runs the strip, pixel and bit counters on tick words and registers one
// result for every word it takes from the queue.
// ----------------------------------------------------------------------------
module bcl_back (
  input  logic           clk,
  input  logic           rst,
  input  bcl_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  bcl_pkg::work_t q_word,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output bcl_pkg::out_t  result
);
  import bcl_pkg::*;

  logic               sending;
  logic [STRIP_W-1:0] strip_index;
  logic [PIXEL_W-1:0] pixel_index;
  logic [BIT_W-1:0]   bit_index;
  logic               phase_high;
  logic [TICK_W-1:0]  tick_counter;
  logic [DIGIT_W-1:0] digit_store [NUM_STRIPS];
  logic               res_valid;

  logic               go;
  logic [LEVEL_W-1:0] level;
  logic [DIGIT_W-1:0] digit;
  logic [BIT_W-1:0]   bit_pos;
  logic               one;
  logic [UNITS_W-1:0] len;
  logic [TICK_W-1:0]  tick_inc;
  logic               phase_done;

  // A word is taken whenever the result register is free or being emptied.
  assign go    = !q_empty && (!res_valid || pop);
  assign q_pop = go;
  assign empty = !res_valid;

  // Line level held before the word and the bit being sent.
  always_comb begin
    level = '0;
    if (sending && phase_high) begin
      level[strip_index] = 1'b1;
    end
    digit = digit_store[NUM_STRIPS-1];
    for (int s = 0; s < NUM_STRIPS; s++) begin
      if (strip_index == STRIP_W'(s)) begin
        digit = digit_store[s];
      end
    end
    bit_pos    = BIT_W'(BITS_PER_PIXEL - 1) - bit_index;
    one        = digit[pixel_index] && cfg.on_color[bit_pos];
    len        = (phase_high == one) ? cfg.long_units : cfg.short_units;
    tick_inc   = tick_counter + 1'b1;
    phase_done = (tick_inc >= TICK_W'(len) + 1'b1);
  end

  // Sequencer state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sending      <= 1'b0;
      strip_index  <= '0;
      pixel_index  <= '0;
      bit_index    <= '0;
      phase_high   <= 1'b0;
      tick_counter <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (go) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      if (go && q_word.mode == MODE_COUNTER && !sending) begin
        sending      <= 1'b1;
        strip_index  <= '0;
        pixel_index  <= '0;
        bit_index    <= '0;
        phase_high   <= 1'b1;
        tick_counter <= '0;
      end else if (go && q_word.mode == MODE_TICK && sending) begin
        if (!phase_done) begin
          tick_counter <= tick_inc;
        end else begin
          tick_counter <= '0;
          if (phase_high) begin
            phase_high <= 1'b0;
          end else begin
            phase_high <= 1'b1;
            if (bit_index != BIT_W'(BITS_PER_PIXEL - 1)) begin
              bit_index <= bit_index + 1'b1;
            end else begin
              bit_index <= '0;
              if (pixel_index != PIXEL_W'(PIXELS_PER_STRIP - 1)) begin
                pixel_index <= pixel_index + 1'b1;
              end else begin
                pixel_index <= '0;
                if (strip_index != STRIP_W'(NUM_STRIPS - 1)) begin
                  strip_index <= strip_index + 1'b1;
                end else begin
                  // Last bit of the last strip ends the refresh.
                  strip_index <= '0;
                  phase_high  <= 1'b0;
                  sending     <= 1'b0;
                end
              end
            end
          end
        end
      end
    end
  end

  // Digits are loaded when a refresh starts; result payload follows each word.
  always_ff @(posedge clk) begin
    if (go && q_word.mode == MODE_COUNTER && !sending) begin
      digit_store[0] <= q_word.ones;
      if (NUM_STRIPS > 1) begin
        digit_store[1 % NUM_STRIPS] <= q_word.tens;
      end
      if (NUM_STRIPS > 2) begin
        digit_store[2 % NUM_STRIPS] <= q_word.hour;
      end
    end
    if (go) begin
      result.line_levels <= level;
      result.dropped     <= (q_word.mode == MODE_COUNTER) && sending;
      if (q_word.mode == MODE_COUNTER) begin
        result.busy_res <= 1'b1;
      end else begin
        result.busy_res <= sending && !(phase_done && !phase_high
                           && bit_index == BIT_W'(BITS_PER_PIXEL - 1)
                           && pixel_index == PIXEL_W'(PIXELS_PER_STRIP - 1)
                           && strip_index == STRIP_W'(NUM_STRIPS - 1));
      end
    end
  end

endmodule
